@@ hw/rtl/dual_motor_encoder_drive_core_defines.svh @@
// assertion macros for the dual motor encoder drive core
// no dependencies; included by files that carry concurrent checks
`ifndef DUAL_MOTOR_ENCODER_DRIVE_CORE_DEFINES_SVH
`define DUAL_MOTOR_ENCODER_DRIVE_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DMED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define DMED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/dmed_pkg.sv @@
// shared types, codes and arithmetic helpers for the dual motor encoder drive
// no dependencies
package dmed_pkg;

  // default encoder counter width
  localparam int COUNT_WIDTH_DEF = 32;

  // field widths
  localparam int OP_W     = 2;
  localparam int VOLT_W   = 17;
  localparam int DB_W     = 8;
  localparam int BAL_W    = 9;
  localparam int GAIN_W   = 24;
  localparam int DUTY_W   = 8;
  localparam int SPEED_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  // count difference after clamping to +/- 2^31
  localparam int DIFF_W   = 33;
  localparam int PROD_W   = DIFF_W + GAIN_W + 1;
  localparam int TERM_W   = DIFF_W + BAL_W;
  localparam int VAL_W    = TERM_W + 1;

  // item kinds
  typedef enum logic [OP_W-1:0] {
    OP_LEFT_EDGE  = 2'd0,
    OP_RIGHT_EDGE = 2'd1,
    OP_SAMPLE     = 2'd2,
    OP_DRIVE      = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_DEADBAND  = 2'd0,
    REG_RIGHT_DEADBAND = 2'd1,
    REG_BALANCE_FACTOR = 2'd2,
    REG_VELOCITY_GAIN  = 2'd3
  } cfg_reg_e;

  // one motor's drive state
  typedef struct packed {
    logic              rev;
    logic [DUTY_W-1:0] duty;
  } drive_t;

  // saturate a speed product to 32-bit signed
  function automatic logic signed [SPEED_W-1:0] sat_speed(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [SPEED_W-1:0] r;
    if (!p[PROD_W-1] && (p[PROD_W-2:SPEED_W-1] != '0)) begin
      r = {1'b0, {(SPEED_W-1){1'b1}}};
    end else if (p[PROD_W-1] && (p[PROD_W-2:SPEED_W-1] != '1)) begin
      r = {1'b1, {(SPEED_W-1){1'b0}}};
    end else begin
      r = p[SPEED_W-1:0];
    end
    return r;
  endfunction

  // deadband and saturation; zero counts as reverse
  function automatic drive_t drive_side(
    input logic signed [VAL_W-1:0] val,
    input logic [DB_W-1:0]         db
  );
    logic signed [VAL_W:0] mag;
    logic signed [VAL_W:0] dbx;
    drive_t r;
    dbx = (VAL_W+1)'($signed({1'b0, db}));
    if (val > 0) begin
      mag   = (VAL_W+1)'(val) + dbx;
      r.rev = 1'b0;
    end else begin
      mag   = dbx - (VAL_W+1)'(val);
      r.rev = 1'b1;
    end
    if (mag > (VAL_W+1)'(255)) begin
      r.duty = '1;
    end else begin
      r.duty = mag[DUTY_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/dmed_diff.sv @@
// wrapped count difference read as signed, clamped to +/- 2^31
// depends on dmed_pkg
module dmed_diff #(
  parameter int COUNT_WIDTH = dmed_pkg::COUNT_WIDTH_DEF
) (
  input  logic [COUNT_WIDTH-1:0]               minuend,
  input  logic [COUNT_WIDTH-1:0]               subtrahend,
  output logic signed [dmed_pkg::DIFF_W-1:0]   diff
);
  import dmed_pkg::*;

  localparam int EW = (COUNT_WIDTH > DIFF_W) ? COUNT_WIDTH : DIFF_W;
  localparam logic signed [EW-1:0] LIM_HI = {{(EW-32){1'b0}}, 1'b1, 31'b0};
  localparam logic signed [EW-1:0] LIM_LO = -LIM_HI;

  logic [COUNT_WIDTH-1:0] raw;
  logic signed [EW-1:0]   ext;

  // modular difference, sign extended
  assign raw = minuend - subtrahend;
  assign ext = EW'($signed(raw));

  // clamp only bites for counters wider than 32 bits
  always_comb begin
    if (ext > LIM_HI) begin
      diff = LIM_HI[DIFF_W-1:0];
    end else if (ext < LIM_LO) begin
      diff = LIM_LO[DIFF_W-1:0];
    end else begin
      diff = ext[DIFF_W-1:0];
    end
  end

endmodule

@@ hw/rtl/dual_motor_encoder_drive_core.sv @@
// top level of the dual motor encoder drive: counting, speed and pwm drive
// depends on dmed_pkg, dmed_diff and dual_motor_encoder_drive_core_defines.svh
//
// Usage: items enter on in_valid/in_ready (op, enc_a, enc_b, drive_voltage),
// results leave on out_valid/out_ready, one result per item, in order. op
// selects a left encoder edge, a right encoder edge, a sample tick or a drive
// command. Each result shows both drive states (reverse, duty) and both
// speeds as they stand after the item.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only while no transaction is in flight.
// An accepted item passes the input register, then the state registers,
// whose update makes its result visible. Throughput: one item per cycle
// unless out_ready stalls; the input register takes a new item while a
// result waits. Each item is done in one pass: input register, one multiply
// or add stage, then the state registers that drive the outputs directly.
// Reset clears the counters, speeds, drive states (forward, duty 0), the
// configuration registers and both valid flags. When the receiver stalls the
// result holds, one more item is buffered, and then in_ready drops.
`include "dual_motor_encoder_drive_core_defines.svh"

module dual_motor_encoder_drive_core #(
  parameter int COUNT_WIDTH = dmed_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // item channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dmed_pkg::OP_W-1:0]             op,
  input  logic                                  enc_a,
  input  logic                                  enc_b,
  input  logic signed [dmed_pkg::VOLT_W-1:0]    drive_voltage,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  left_reverse,
  output logic [dmed_pkg::DUTY_W-1:0]           left_duty,
  output logic                                  right_reverse,
  output logic [dmed_pkg::DUTY_W-1:0]           right_duty,
  output logic signed [dmed_pkg::SPEED_W-1:0]   left_speed,
  output logic signed [dmed_pkg::SPEED_W-1:0]   right_speed,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dmed_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dmed_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dmed_pkg::*;

  // configuration registers
  logic [DB_W-1:0]          left_deadband;
  logic [DB_W-1:0]          right_deadband;
  logic signed [BAL_W-1:0]  balance_factor;
  logic [GAIN_W-1:0]        velocity_gain;

  // input register
  logic                     s1_valid;
  op_e                      s1_op;
  logic                     s1_a;
  logic                     s1_b;
  logic signed [VOLT_W-1:0] s1_volt;

  // state
  logic [COUNT_WIDTH-1:0]    left_count;
  logic [COUNT_WIDTH-1:0]    right_count;
  logic [COUNT_WIDTH-1:0]    left_prev_count;
  logic [COUNT_WIDTH-1:0]    right_prev_count;
  logic signed [SPEED_W-1:0] left_speed_reg;
  logic signed [SPEED_W-1:0] right_speed_reg;
  drive_t                    left_drive_reg;
  drive_t                    right_drive_reg;

  logic advance;

  // combinational datapath
  logic signed [DIFF_W-1:0] left_diff;
  logic signed [DIFF_W-1:0] right_diff;
  logic signed [DIFF_W-1:0] bal_diff;
  logic signed [PROD_W-1:0] left_prod;
  logic signed [PROD_W-1:0] right_prod;
  logic signed [26:0]       volt_num;
  logic [26:0]              volt_mag;
  logic [10:0]              volt_hi;
  logic [20:0]              third_prod;
  logic [9:0]               base_mag;
  logic signed [10:0]       base;
  logic signed [TERM_W-1:0] bal_term;
  logic signed [VAL_W-1:0]  left_val;
  logic signed [VAL_W-1:0]  right_val;
  drive_t                   left_drive_next;
  drive_t                   right_drive_next;

  // handshake: the input register moves whenever the result slot frees up
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // outputs come straight from the state registers
  assign left_reverse  = left_drive_reg.rev;
  assign left_duty     = left_drive_reg.duty;
  assign right_reverse = right_drive_reg.rev;
  assign right_duty    = right_drive_reg.duty;
  assign left_speed    = left_speed_reg;
  assign right_speed   = right_speed_reg;

  // clamped count differences
  dmed_diff #(.COUNT_WIDTH(COUNT_WIDTH)) u_left_diff (
    .minuend   (left_count),
    .subtrahend(left_prev_count),
    .diff      (left_diff)
  );

  dmed_diff #(.COUNT_WIDTH(COUNT_WIDTH)) u_right_diff (
    .minuend   (right_count),
    .subtrahend(right_prev_count),
    .diff      (right_diff)
  );

  dmed_diff #(.COUNT_WIDTH(COUNT_WIDTH)) u_bal_diff (
    .minuend   (right_count),
    .subtrahend(left_count),
    .diff      (bal_diff)
  );

  // speed products
  assign left_prod  = PROD_W'(left_diff)  * PROD_W'($signed({1'b0, velocity_gain}));
  assign right_prod = PROD_W'(right_diff) * PROD_W'($signed({1'b0, velocity_gain}));

  // voltage scaling: trunc((510 v + 49152) / 98304) toward zero,
  // divide by 32768 with a shift, then by 3 with a reciprocal multiply
  assign volt_num   = 27'(s1_volt) * 27'sd510 + 27'sd49152;
  assign volt_mag   = volt_num[26] ? 27'(-volt_num) : volt_num;
  assign volt_hi    = volt_mag[25:15];
  assign third_prod = 21'(volt_hi) * 21'd683;
  assign base_mag   = third_prod[20:11];
  assign base       = volt_num[26] ? -$signed({1'b0, base_mag}) : $signed({1'b0, base_mag});

  // balance term and per-side drive
  assign bal_term  = TERM_W'(balance_factor) * TERM_W'(bal_diff);
  assign left_val  = VAL_W'(base) + VAL_W'(bal_term);
  assign right_val = VAL_W'(base) - VAL_W'(bal_term);
  assign left_drive_next  = drive_side(left_val, left_deadband);
  assign right_drive_next = drive_side(right_val, right_deadband);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      left_deadband  <= '0;
      right_deadband <= '0;
      balance_factor <= '0;
      velocity_gain  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_LEFT_DEADBAND:  left_deadband  <= cfg_data[DB_W-1:0];
        REG_RIGHT_DEADBAND: right_deadband <= cfg_data[DB_W-1:0];
        REG_BALANCE_FACTOR: balance_factor <= $signed(cfg_data[BAL_W-1:0]);
        REG_VELOCITY_GAIN:  velocity_gain  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= op_e'(op);
      s1_a    <= enc_a;
      s1_b    <= enc_b;
      s1_volt <= drive_voltage;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  // state update, one transaction per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count       <= '0;
      right_count      <= '0;
      left_prev_count  <= '0;
      right_prev_count <= '0;
      left_speed_reg   <= '0;
      right_speed_reg  <= '0;
      left_drive_reg   <= '0;
      right_drive_reg  <= '0;
    end else if (advance) begin
      unique case (s1_op)
        OP_LEFT_EDGE: begin
          if (s1_a != s1_b) begin
            left_count <= left_count - COUNT_WIDTH'(1);
          end else begin
            left_count <= left_count + COUNT_WIDTH'(1);
          end
        end
        OP_RIGHT_EDGE: begin
          if (s1_a != s1_b) begin
            right_count <= right_count + COUNT_WIDTH'(1);
          end else begin
            right_count <= right_count - COUNT_WIDTH'(1);
          end
        end
        OP_SAMPLE: begin
          left_speed_reg   <= sat_speed(left_prod);
          right_speed_reg  <= sat_speed(right_prod);
          left_prev_count  <= left_count;
          right_prev_count <= right_count;
        end
        OP_DRIVE: begin
          left_drive_reg  <= left_drive_next;
          right_drive_reg <= right_drive_next;
        end
        default: ;
      endcase
    end
  end

  // checks
  `DMED_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready,
    $stable(left_drive_reg) && $stable(right_drive_reg) && $stable(left_speed_reg) &&
    $stable(right_speed_reg) && $stable(left_count) && $stable(right_count),
    "result changed while stalled")
  `DMED_ASSERT_NEXT(a_no_phantom, clk, rst, !s1_valid && (!out_valid || out_ready),
    !out_valid, "result without a transaction")
  `DMED_ASSERT_NOW(a_ready_when_free, clk, rst, !out_valid || out_ready,
    in_ready, "input blocked while result slot is free")
  `DMED_ASSERT_NEXT(a_buffered_kept, clk, rst, s1_valid && out_valid && !out_ready,
    s1_valid, "buffered transaction dropped")

endmodule
